FILE: sv/dda_pkg.sv
// Shared constants, codes and item types of the DDA line pixel generator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  // Screen size in pixels
  localparam int SCREEN_ROWS = 1024;
  localparam int SCREEN_COLS = 2048;

  // Field and state widths
  localparam int COORD_W    = 24;  // Q15.8 endpoint
  localparam int FRAC_IN    = 8;   // fraction bits of an endpoint
  localparam int POS_W      = 32;  // Q15.16 position
  localparam int FRAC_POS   = 16;  // fraction bits of a position
  localparam int STEP_W     = 18;  // Q1.16 signed increment
  localparam int QUOT_W     = 17;  // increment magnitude, up to one pixel
  localparam int CNT_W      = 17;  // pixels left in a segment
  localparam int MAG_W      = 24;  // absolute delta and span
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 32;
  localparam int PITCH_W    = 16;
  localparam int BPP_W      = 6;
  localparam int BYTE_SHIFT = 3;   // bits to bytes

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_PIXEL = 2'd2;

  localparam logic [PITCH_W-1:0] LINE_PITCH_RST = 16'd8192;
  localparam logic [BPP_W-1:0]   BPP_RST        = 6'd32;

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [COORD_W-1:0] start_row;
    logic signed [COORD_W-1:0] start_col;
    logic signed [COORD_W-1:0] end_row;
    logic signed [COORD_W-1:0] end_col;
    logic [COLOR_W-1:0]        pixel_color;
  } in_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_value;
    logic               last;
    logic               busy_res;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] span;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/dda_if.sv
// Valid/ready channels for input items and result items.
// Depends on dda_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface dda_in_if;
  import dda_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dda_out_if;
  import dda_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dda_line_pixel_generator_core.sv
// Top level of the DDA line pixel generator: sequencer, position walk and
// address generation. Depends on dda_pkg, dda_if.sv and dda_div.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   in_ch   | in  | valid/ready        | cmd, endpoints (Q15.8), pixel_color
//   out_ch  | out | valid/ready        | write_enable, address, value, last, busy
//   cfg_*   | in  | cfg_we, no stall   | frame_base, line_pitch, bits_per_pixel
//
// A tick item's result is registered in the output stage, and the next item
// is taken in the following cycle as long as out_ch drains.
// A load item's result is registered at once; then the shared restoring
// divider runs twice (row, then column), 17 quotient bits each, and
// in_ch.ready stays low until both increments land.
// Reset (synchronous, rst_n low) idles the sequencer and empties the output
// stage; a stalled out_ch holds the result and blocks new items.
`timescale 1ns / 1ps
`default_nettype none

module dda_line_pixel_generator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  dda_in_if.sink                           in_ch,
  dda_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [dda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dda_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dda_pkg::*;

  localparam int PIX_W = POS_W - FRAC_POS - 1;  // on-screen pixel index bits

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_GO,
    S_ROW_RUN,
    S_COL_GO,
    S_COL_RUN
  } state_t;

  // Configuration
  logic [ADDR_W-1:0]  frame_base_r;
  logic [PITCH_W-1:0] line_pitch_r;
  logic [BPP_W-1:0]   bpp_r;

  // Segment state
  state_t             state_r;
  logic               active_r;
  logic [POS_W-1:0]   cur_row_r;
  logic [POS_W-1:0]   cur_col_r;
  logic [STEP_W-1:0]  row_step_r;
  logic [STEP_W-1:0]  col_step_r;
  logic [CNT_W-1:0]   steps_left_r;
  logic [COLOR_W-1:0] held_color_r;

  // Operands held for the divider
  logic [MAG_W-1:0]   mag_row_r;
  logic [MAG_W-1:0]   mag_col_r;
  logic [MAG_W-1:0]   span_r;
  logic               neg_row_r;
  logic               neg_col_r;

  // Output stage
  logic               out_valid_r;
  out_item_t          out_r;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               in_fire;
  logic               is_load;

  // Load datapath
  logic signed [COORD_W:0] d_row;
  logic signed [COORD_W:0] d_col;
  logic [COORD_W:0]   a_row;
  logic [COORD_W:0]   a_col;
  logic [MAG_W-1:0]   span_nxt;
  logic [POS_W-1:0]   row_init;
  logic [POS_W-1:0]   col_init;
  logic [CNT_W-1:0]   steps_init;

  // Tick datapath
  logic               on_screen;
  logic [PIX_W-1:0]   pix_row;
  logic [PIX_W-1:0]   pix_col;
  logic [PIX_W+PITCH_W-1:0] row_bytes;
  logic [PIX_W+BPP_W-1:0]   col_bits;
  logic [ADDR_W-1:0]  addr_nxt;
  logic [CNT_W-1:0]   steps_dec;
  out_item_t          res_nxt;

  // Increment from the divider
  logic [STEP_W-1:0]  q_ext;
  logic               q_neg;
  logic [STEP_W-1:0]  step_nxt;

  dda_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Take an item only when idle and the output stage frees up this cycle
  assign in_ch.ready  = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_load      = (in_ch.data.cmd == CMD_LOAD);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    div_req.start = (state_r == S_ROW_GO) || (state_r == S_COL_GO);
    div_req.mag   = (state_r == S_COL_GO) ? mag_col_r : mag_row_r;
    div_req.span  = span_r;
  end

  // Deltas, span and start position of a new segment
  always_comb begin
    d_row      = $signed({in_ch.data.end_row[COORD_W-1], in_ch.data.end_row})
                 - $signed({in_ch.data.start_row[COORD_W-1], in_ch.data.start_row});
    d_col      = $signed({in_ch.data.end_col[COORD_W-1], in_ch.data.end_col})
                 - $signed({in_ch.data.start_col[COORD_W-1], in_ch.data.start_col});
    a_row      = d_row[COORD_W] ? (COORD_W+1)'(-d_row) : d_row;
    a_col      = d_col[COORD_W] ? (COORD_W+1)'(-d_col) : d_col;
    span_nxt   = (a_row > a_col) ? a_row[MAG_W-1:0] : a_col[MAG_W-1:0];
    row_init   = POS_W'(in_ch.data.start_row) << FRAC_IN;
    col_init   = POS_W'(in_ch.data.start_col) << FRAC_IN;
    steps_init = CNT_W'(span_nxt >> FRAC_IN) + CNT_W'(1);
  end

  // Pixel write of the current position; negative and off-screen positions are clipped
  always_comb begin
    on_screen = !cur_row_r[POS_W-1] && !cur_col_r[POS_W-1]
                && (cur_row_r[POS_W-1:FRAC_POS] < (POS_W-FRAC_POS)'(SCREEN_ROWS))
                && (cur_col_r[POS_W-1:FRAC_POS] < (POS_W-FRAC_POS)'(SCREEN_COLS));
    pix_row   = cur_row_r[POS_W-2:FRAC_POS];
    pix_col   = cur_col_r[POS_W-2:FRAC_POS];
    row_bytes = (PIX_W+PITCH_W)'(pix_row) * (PIX_W+PITCH_W)'(line_pitch_r);
    col_bits  = (PIX_W+BPP_W)'(pix_col) * (PIX_W+BPP_W)'(bpp_r);
    addr_nxt  = frame_base_r + ADDR_W'(row_bytes) + ADDR_W'(col_bits >> BYTE_SHIFT);
    steps_dec = steps_left_r - CNT_W'(1);

    res_nxt = '0;
    if (is_load) begin
      res_nxt.busy_res = 1'b1;
    end else if (active_r) begin
      if (on_screen) begin
        res_nxt.write_enable  = 1'b1;
        res_nxt.pixel_address = addr_nxt;
        res_nxt.pixel_value   = held_color_r;
      end
      res_nxt.last     = (steps_dec == '0);
      res_nxt.busy_res = (steps_dec != '0);
    end
  end

  // Signed increment; a zero span means a single pixel with no motion
  always_comb begin
    q_ext    = STEP_W'(div_rsp.quot);
    q_neg    = (state_r == S_COL_RUN) ? neg_col_r : neg_row_r;
    step_nxt = (span_r == '0) ? '0 : (q_neg ? STEP_W'(-q_ext) : q_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      line_pitch_r <= LINE_PITCH_RST;
      bpp_r        <= BPP_RST;
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Configuration writes; unknown indexes drop
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_BASE:     frame_base_r <= cfg_wdata[ADDR_W-1:0];
          CFG_LINE_PITCH:     line_pitch_r <= cfg_wdata[PITCH_W-1:0];
          CFG_BITS_PER_PIXEL: bpp_r        <= cfg_wdata[BPP_W-1:0];
          default: ;
        endcase
      end

      // Output stage: load on accept, empty when taken
      if (in_fire) begin
        out_valid_r <= 1'b1;
        out_r       <= res_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && is_load) begin
            cur_row_r    <= row_init;
            cur_col_r    <= col_init;
            steps_left_r <= steps_init;
            held_color_r <= in_ch.data.pixel_color;
            mag_row_r    <= a_row[MAG_W-1:0];
            mag_col_r    <= a_col[MAG_W-1:0];
            neg_row_r    <= d_row[COORD_W];
            neg_col_r    <= d_col[COORD_W];
            span_r       <= span_nxt;
            active_r     <= 1'b1;
            state_r      <= S_ROW_GO;
          end else if (in_fire && active_r) begin
            // Advance one increment, wrapping modulo 2^32
            cur_row_r    <= cur_row_r + POS_W'($signed(row_step_r));
            cur_col_r    <= cur_col_r + POS_W'($signed(col_step_r));
            steps_left_r <= steps_dec;
            if (steps_dec == '0) begin
              active_r <= 1'b0;
            end
          end
        end
        S_ROW_GO:  state_r <= S_ROW_RUN;
        S_ROW_RUN: begin
          if (div_rsp.done) begin
            row_step_r <= step_nxt;
            state_r    <= S_COL_GO;
          end
        end
        S_COL_GO:  state_r <= S_COL_RUN;
        S_COL_RUN: begin
          if (div_rsp.done) begin
            col_step_r <= step_nxt;
            state_r    <= S_IDLE;
          end
        end
        default:   state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A load starts the row division in the next cycle
  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_load) |=> (state_r == S_ROW_GO))
    else $error("load did not start the divider");

  // The divider only reports while the sequencer waits for it
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_ROW_RUN || state_r == S_COL_RUN))
    else $error("divider result outside a wait state");

  // The final tick ends the segment and flags it
  a_final_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_load && active_r && steps_left_r == CNT_W'(1))
    |=> (!active_r && out_valid_r && out_r.last && !out_r.busy_res))
    else $error("final tick did not close the segment");

  // A pixel write always carries the segment color
  a_write_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.write_enable) |-> (out_r.pixel_value == held_color_r))
    else $error("pixel value differs from segment color");
`endif

endmodule

`default_nettype wire

FILE: sv/dda_div.sv
// Restoring divider, one quotient bit per cycle: floor(mag * 2^16 / span).
// Requires mag <= span and span != 0. Depends on dda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dda_div (
  input  logic              clk,
  input  logic              rst_n,
  input  dda_pkg::div_req_t req_i,
  output dda_pkg::div_rsp_t rsp_o
);
  import dda_pkg::*;

  localparam int ITC_W = $clog2(QUOT_W);
  localparam logic [ITC_W-1:0] ITC_LAST = ITC_W'(QUOT_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [ITC_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  rem_r;
  logic [MAG_W-1:0]  span_r;
  logic [QUOT_W-1:0] quot_r;

  logic [MAG_W:0]    trial;
  logic [MAG_W:0]    diff;
  logic              fits;
  logic [MAG_W-1:0]  rem_nxt;
  logic [QUOT_W-1:0] quot_nxt;

  // First bit compares the unshifted remainder (quotient bit of weight 2^16)
  always_comb begin
    trial    = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff     = trial - {1'b0, span_r};
    fits     = trial >= {1'b0, span_r};
    rem_nxt  = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
    quot_nxt = {quot_r[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req_i.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= req_i.mag;
      span_r <= req_i.span;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
      if (cnt_r == ITC_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + ITC_W'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quot = quot_r;

endmodule

`default_nettype wire
